/* rtl/swmm_pkg.sv */
// Shared constants and types for the sliding window min/max block.
`timescale 1ns / 1ps
package swmm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int MIN_WINDOW  = 2;
  localparam int WS_RESET    = 8;
  localparam int WS_BITS     = $clog2(WINDOW_MAX + 1);
  localparam int POS_BITS    = $clog2(4 * WINDOW_MAX);

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_BITS-1:0]           posn;
  } entry_t;

  typedef struct packed {
    logic                          step;
    logic                          insert;
    logic                          clr;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [POS_BITS-1:0]           curpos;
    logic [WS_BITS-1:0]            ws;
  } ctrl_t;

  typedef struct packed {
    logic                          more;
    logic signed [SAMPLE_BITS-1:0] front;
  } stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

endpackage

/* rtl/swmm_if.sv */
// Handshake channels for samples, results and the window size register.
`timescale 1ns / 1ps
interface swmm_item_if import swmm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          clear_first;
  modport source (output valid, sample, clear_first, input ready);
  modport sink (input valid, sample, clear_first, output ready);
endinterface

interface swmm_result_if import swmm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic                          window_full;
  modport source (output valid, window_min, window_max, window_full, input ready);
  modport sink (input valid, window_min, window_max, window_full, output ready);
endinterface

interface swmm_cfg_if import swmm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WS_BITS-1:0] window_size;
  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

/* rtl/swmm_cell.sv */
// One queue cell: holds an entry, shifts from its right neighbor, evicts or takes the sample.
`timescale 1ns / 1ps
module swmm_cell import swmm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   keep_greater,
  input  logic   shift,
  input  ctrl_t  ctrl,
  input  entry_t right,
  input  logic   prev_keep,
  output logic   keep,
  output entry_t cur,
  output entry_t nxt
);

  entry_t view;
  logic   evict;

  always_comb begin
    view = shift ? right : cur;
    view.valid = view.valid & ~ctrl.clr;
    if (keep_greater) begin
      evict = $signed(view.value) <= $signed(ctrl.sample);
    end else begin
      evict = $signed(view.value) >= $signed(ctrl.sample);
    end
    keep = view.valid & ~evict;
    nxt = cur;
    if (ctrl.step) begin
      nxt = view;
      if (ctrl.insert && !keep) begin
        nxt.valid = prev_keep;
        nxt.value = ctrl.sample;
        nxt.posn  = ctrl.curpos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= nxt.valid;
    end
    cur.value <= nxt.value;
    cur.posn  <= nxt.posn;
  end

endmodule

/* rtl/swmm_queue.sv */
// Monotonic queue built as a row of cells; while stepping, expires at most one front entry per cycle.
`timescale 1ns / 1ps
module swmm_queue import swmm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  keep_greater,
  input  ctrl_t ctrl,
  output stat_t stat
);

  entry_t              cur [WINDOW_MAX];
  logic                keep [WINDOW_MAX];
  entry_t              head_next;
  logic [POS_BITS-1:0] age0;
  logic [POS_BITS-1:0] age1;
  logic                exp0;
  logic                exp1;
  logic                shift;

  assign age0  = ctrl.curpos - cur[0].posn;
  assign age1  = ctrl.curpos - cur[1].posn;
  assign exp0  = cur[0].valid & ~ctrl.clr & (age0 >= POS_BITS'(ctrl.ws));
  assign exp1  = cur[1].valid & ~ctrl.clr & (age1 >= POS_BITS'(ctrl.ws));
  assign shift = ctrl.step & exp0;

  assign stat.more  = exp0 & exp1;
  assign stat.front = head_next.value;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    entry_t right;
    logic   prev_keep;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cur[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      swmm_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .keep_greater (keep_greater),
        .shift        (shift),
        .ctrl         (ctrl),
        .right        (right),
        .prev_keep    (prev_keep),
        .keep         (keep[i]),
        .cur          (cur[i]),
        .nxt          (head_next)
      );
    end else begin : g_body
      assign prev_keep = keep[i-1];
      swmm_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .keep_greater (keep_greater),
        .shift        (shift),
        .ctrl         (ctrl),
        .right        (right),
        .prev_keep    (prev_keep),
        .keep         (keep[i]),
        .cur          (cur[i]),
        .nxt          ()
      );
    end
  end

endmodule

/* rtl/sliding_window_min_max.sv */
// Sliding window min/max top level: handshake, window bookkeeping, two monotonic queues.
//
// Each accepted sample is worked from the cycle after it is taken, and its result is
// registered at the end of the cycle in which that work finishes; the block takes one
// sample per clock while no expiry or result stall holds it. Each queue drops at most one
// expired entry from its front per cycle: after window_size is lowered, work on the
// next sample stalls while either queue holds more than one expired entry at its front.
// A result that is not taken stalls the block only once the following sample is ready
// to finish. There is no clearing pass after reset; window_size resets to 8 and is
// saturated into [2, 64] on write.
`timescale 1ns / 1ps
module sliding_window_min_max import swmm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  swmm_item_if.sink     item,
  swmm_result_if.source result,
  swmm_cfg_if.sink      cfg
);

  state_t                        state;
  state_t                        state_next;
  logic [WS_BITS-1:0]            ws;
  logic [WS_BITS-1:0]            ws_next;
  logic [WS_BITS-1:0]            fill;
  logic [POS_BITS-1:0]           pos;
  logic signed [SAMPLE_BITS-1:0] hold_sample;
  logic                          hold_clr;
  logic                          res_valid;
  logic                          acc;
  logic                          out_free;
  logic                          all_done;
  logic                          finish;
  ctrl_t                         ctrl;
  stat_t                         stat_max;
  stat_t                         stat_min;

  assign acc      = item.valid & item.ready;
  assign out_free = ~res_valid | result.ready;
  assign all_done = ~stat_max.more & ~stat_min.more;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) state_next = ST_WORK;
      end
      ST_WORK: begin
        if (finish && !acc) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    finish     = (state == ST_WORK) & all_done & out_free;
    item.ready = (state == ST_IDLE) | finish;
  end

  always_comb begin
    ws_next = cfg.window_size;
    if (cfg.window_size < WS_BITS'(MIN_WINDOW)) ws_next = WS_BITS'(MIN_WINDOW);
    if (cfg.window_size > WS_BITS'(WINDOW_MAX)) ws_next = WS_BITS'(WINDOW_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ws    <= WS_BITS'(WS_RESET);
      fill  <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) ws <= ws_next;
      if (acc) begin
        if (item.clear_first) begin
          pos  <= '0;
          fill <= WS_BITS'(1);
        end else begin
          if (fill != '0) pos <= pos + POS_BITS'(1);
          if (fill < WS_BITS'(WINDOW_MAX)) fill <= fill + WS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hold_sample <= item.sample;
      hold_clr    <= item.clear_first;
    end
  end

  always_comb begin
    ctrl.step   = (state == ST_WORK);
    ctrl.insert = finish;
    ctrl.clr    = hold_clr;
    ctrl.sample = hold_sample;
    ctrl.curpos = pos;
    ctrl.ws     = ws;
  end

  swmm_queue u_max_queue (
    .clk          (clk),
    .rst          (rst),
    .keep_greater (1'b1),
    .ctrl         (ctrl),
    .stat         (stat_max)
  );

  swmm_queue u_min_queue (
    .clk          (clk),
    .rst          (rst),
    .keep_greater (1'b0),
    .ctrl         (ctrl),
    .stat         (stat_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.window_min  <= stat_min.front;
      result.window_max  <= stat_max.front;
      result.window_full <= (fill >= ws);
    end
  end

  assign result.valid = res_valid;

  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> !(res_valid && !result.ready))
    else $error("result overwritten before it was taken");

  a_idle_no_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ctrl.insert)
    else $error("queue insert while idle");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (finish && !acc) |=> (state == ST_IDLE))
    else $error("block stayed busy after last beat finished");

  a_ws_range: assert property (@(posedge clk) disable iff (rst)
    (ws >= WS_BITS'(MIN_WINDOW)) && (ws <= WS_BITS'(WINDOW_MAX)))
    else $error("window size out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= WS_BITS'(WINDOW_MAX))
    else $error("fill count past window limit");

endmodule
